// File: hw/rtl/tcc_pkg.sv
// ----------------------------------------------------------------------------
// tcc_pkg: shared types and widths of the triangle circumcenter pipeline
// Exact integer widths of the shared intermediates, status codes, result struct.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int unsigned CoordW = 32;   // vertex and center coordinate width
  localparam int unsigned QuoW   = 32;   // quotient bits resolved by the divider
  localparam int unsigned DenW   = 134;  // D = 2 (n . n), nonnegative
  localparam int unsigned MagW   = 169;  // |C * D + t|

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DEGEN = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    status_e                  status;
  } res_t;

endpackage

// File: hw/rtl/tcc_div.sv
// ----------------------------------------------------------------------------
// tcc_div: pipelined restoring divider and result formatting
// Three lanes share one denominator; one quotient bit per stage, then
// saturation, sign restore and status.
// ----------------------------------------------------------------------------
module tcc_div import tcc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            vld_i,
  input  logic [MagW-1:0] mag_i [3],
  input  logic [DenW-1:0] den_i,
  input  logic [2:0]      neg_i,
  input  logic            deg_i,
  output logic            vld_o,
  output res_t            res_o
);

  localparam int unsigned Steps = QuoW;

  logic [Steps:0]      vld_q;
  logic [Steps:0]      deg_q;
  logic [2:0]          neg_q  [Steps+1];
  logic [2:0]          high_q [Steps+1];
  logic [DenW-1:0]     den_q  [Steps+1];
  logic [MagW-1:0]     rem_q  [Steps+1][3];
  logic [QuoW-1:0]     quo_q  [Steps+1][3];
  logic [2:0]          high_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[Steps-1:0], vld_i};
    end
  end

  // quotient of 2^32 or more always saturates
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      high_d[k] = mag_i[k] >= (MagW'(den_i) << QuoW);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      deg_q[0]  <= deg_i;
      neg_q[0]  <= neg_i;
      high_q[0] <= high_d;
      den_q[0]  <= den_i;
      for (int k = 0; k < 3; k++) begin
        rem_q[0][k] <= mag_i[k];
        quo_q[0][k] <= '0;
      end
    end
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [MagW-1:0] dsh;
    logic [MagW-1:0] rem_d [3];
    logic [QuoW-1:0] quo_d [3];

    always_comb begin
      dsh = MagW'(den_q[s]) << (QuoW - 1 - s);
      for (int k = 0; k < 3; k++) begin
        rem_d[k] = rem_q[s][k];
        quo_d[k] = quo_q[s][k];
        if (rem_q[s][k] >= dsh) begin
          rem_d[k] = rem_q[s][k] - dsh;
          quo_d[k][QuoW-1-s] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        deg_q[s+1]  <= deg_q[s];
        neg_q[s+1]  <= neg_q[s];
        high_q[s+1] <= high_q[s];
        den_q[s+1]  <= den_q[s];
        for (int k = 0; k < 3; k++) begin
          rem_q[s+1][k] <= rem_d[k];
          quo_q[s+1][k] <= quo_d[k];
        end
      end
    end
  end

  logic [CoordW-1:0] lim [3];
  logic [CoordW-1:0] mv  [3];
  logic [CoordW-1:0] val [3];
  logic [2:0]        over;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      // negative side reaches one step further
      lim[k]  = neg_q[Steps][k] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
      over[k] = high_q[Steps][k] || (quo_q[Steps][k] > lim[k]);
      mv[k]   = over[k] ? lim[k] : quo_q[Steps][k];
      val[k]  = neg_q[Steps][k] ? (~mv[k] + 1'b1) : mv[k];
    end
    if (deg_q[Steps]) begin
      res_o.x      = '0;
      res_o.y      = '0;
      res_o.z      = '0;
      res_o.status = ST_DEGEN;
    end else begin
      res_o.x      = $signed(val[0]);
      res_o.y      = $signed(val[1]);
      res_o.z      = $signed(val[2]);
      res_o.status = (over != 3'b000) ? ST_SAT : ST_OK;
    end
  end

  assign vld_o = vld_q[Steps];

endmodule

// File: hw/rtl/triangle_circumcenter.sv
// ----------------------------------------------------------------------------
// triangle_circumcenter: exact 3D circumcenter of a triangle
// Accepts one triangle per cycle while input ready is high; 8 arithmetic stages,
// a 33-stage bit-per-stage divider, then an output register with a one-entry skid.
// Input ready drops only while the skid entry is occupied.
// Reset clears valid bits and the output/skid flags; payload is not reset.
// ----------------------------------------------------------------------------
module triangle_circumcenter import tcc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [CoordW-1:0] ax_i,
  input  logic signed [CoordW-1:0] ay_i,
  input  logic signed [CoordW-1:0] az_i,
  input  logic signed [CoordW-1:0] bx_i,
  input  logic signed [CoordW-1:0] by_coord_i,
  input  logic signed [CoordW-1:0] bz_i,
  input  logic signed [CoordW-1:0] cx_i,
  input  logic signed [CoordW-1:0] cy_i,
  input  logic signed [CoordW-1:0] cz_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [CoordW-1:0] center_x_o,
  output logic signed [CoordW-1:0] center_y_o,
  output logic signed [CoordW-1:0] center_z_o,
  output logic [1:0]               status_o
);

  localparam int unsigned IdxA [3] = '{1, 2, 0};
  localparam int unsigned IdxB [3] = '{2, 0, 1};
  localparam int unsigned DifW = CoordW + 1;  // 33
  localparam int unsigned NW   = 67;          // cross product a x b
  localparam int unsigned AW   = 68;          // |a|^2, |b|^2
  localparam int unsigned UW   = 104;         // |a|^2 b - |b|^2 a
  localparam int unsigned NumW = 170;         // C * D + t

  logic en;
  logic [7:0] vld_q;

  logic signed [CoordW-1:0] pa [3], pb [3], pc [3];
  assign pa[0] = ax_i; assign pa[1] = ay_i;       assign pa[2] = az_i;
  assign pb[0] = bx_i; assign pb[1] = by_coord_i; assign pb[2] = bz_i;
  assign pc[0] = cx_i; assign pc[1] = cy_i;       assign pc[2] = cz_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[6:0], in_valid_i};
    end
  end

  // stage 1: edge vectors
  logic signed [DifW-1:0]   a1_d [3], b1_d [3], a1_q [3], b1_q [3];
  logic signed [CoordW-1:0] c1_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a1_d[k] = DifW'(pa[k]) - DifW'(pc[k]);
      b1_d[k] = DifW'(pb[k]) - DifW'(pc[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q <= a1_d;
      b1_q <= b1_d;
      c1_q <= pc;
    end
  end

  // stage 2: normal n = a x b, squared lengths
  logic signed [NW-1:0]     n2_d [3], n2_q [3];
  logic signed [AW-1:0]     aa2_d, bb2_d, aa2_q, bb2_q;
  logic signed [DifW-1:0]   a2_q [3], b2_q [3];
  logic signed [CoordW-1:0] c2_q [3];
  logic signed [2*DifW-1:0] pn0 [3], pn1 [3], sqa [3], sqb [3];

  always_comb begin
    aa2_d = '0;
    bb2_d = '0;
    for (int k = 0; k < 3; k++) begin
      pn0[k] = a1_q[IdxA[k]] * b1_q[IdxB[k]];
      pn1[k] = a1_q[IdxB[k]] * b1_q[IdxA[k]];
      n2_d[k] = NW'(pn0[k]) - NW'(pn1[k]);
      sqa[k] = a1_q[k] * a1_q[k];
      sqb[k] = b1_q[k] * b1_q[k];
      aa2_d = aa2_d + AW'(sqa[k]);
      bb2_d = bb2_d + AW'(sqb[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n2_q  <= n2_d;
      aa2_q <= aa2_d;
      bb2_q <= bb2_d;
      a2_q  <= a1_q;
      b2_q  <= b1_q;
      c2_q  <= c1_q;
    end
  end

  // stage 3: split partial products of n.n and of the u terms
  logic signed [32:0] nh [3];
  logic signed [34:0] nl [3];
  logic signed [33:0] ah, bh;
  logic signed [34:0] al, bl;
  logic signed [65:0] phh3_d [3], phh3_q [3];
  logic signed [67:0] phl3_d [3], phl3_q [3];
  logic signed [69:0] pll3_d [3], pll3_q [3];
  logic signed [66:0] pah3_d [3], pah3_q [3], pbh3_d [3], pbh3_q [3];
  logic signed [67:0] pal3_d [3], pal3_q [3], pbl3_d [3], pbl3_q [3];
  logic signed [NW-1:0]     n3_q [3];
  logic signed [CoordW-1:0] c3_q [3];

  always_comb begin
    ah = $signed(aa2_q[AW-1:34]);
    al = $signed({1'b0, aa2_q[33:0]});
    bh = $signed(bb2_q[AW-1:34]);
    bl = $signed({1'b0, bb2_q[33:0]});
    for (int k = 0; k < 3; k++) begin
      nh[k]     = $signed(n2_q[k][NW-1:34]);
      nl[k]     = $signed({1'b0, n2_q[k][33:0]});
      phh3_d[k] = nh[k] * nh[k];
      phl3_d[k] = nh[k] * nl[k];
      pll3_d[k] = nl[k] * nl[k];
      pah3_d[k] = ah * b2_q[k];
      pal3_d[k] = al * b2_q[k];
      pbh3_d[k] = bh * a2_q[k];
      pbl3_d[k] = bl * a2_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      phh3_q <= phh3_d;
      phl3_q <= phl3_d;
      pll3_q <= pll3_d;
      pah3_q <= pah3_d;
      pal3_q <= pal3_d;
      pbh3_q <= pbh3_d;
      pbl3_q <= pbl3_d;
      n3_q   <= n2_q;
      c3_q   <= c2_q;
    end
  end

  // stage 4: D = 2 (n . n), u = |a|^2 b - |b|^2 a
  logic signed [135:0]      dsum;
  logic [DenW-1:0]          d4_d, d4_q;
  logic signed [UW-1:0]     u4_d [3], u4_q [3];
  logic signed [NW-1:0]     n4_q [3];
  logic signed [CoordW-1:0] c4_q [3];

  always_comb begin
    dsum = '0;
    for (int k = 0; k < 3; k++) begin
      dsum = dsum + (136'(phh3_q[k]) <<< 68) + (136'(phl3_q[k]) <<< 35)
                  + 136'(pll3_q[k]);
      u4_d[k] = (UW'(pah3_q[k]) <<< 34) + UW'(pal3_q[k])
              - (UW'(pbh3_q[k]) <<< 34) - UW'(pbl3_q[k]);
    end
    d4_d = {dsum[DenW-2:0], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d4_q <= d4_d;
      u4_q <= u4_d;
      n4_q <= n3_q;
      c4_q <= c3_q;
    end
  end

  // stage 5: partial products of t = u x n and of C * D
  logic signed [35:0] uc [3][3];
  logic signed [34:0] nc [3][2];
  logic signed [34:0] dc [4];
  logic [135:0]       dpad;
  logic signed [70:0] tp5_d [3][2][6], tp5_q [3][2][6];
  logic signed [66:0] cd5_d [3][4], cd5_q [3][4];
  logic [DenW-1:0]    d5_q;

  always_comb begin
    dpad = {2'b00, d4_q};
    for (int j = 0; j < 4; j++) begin
      dc[j] = $signed({1'b0, dpad[34*j +: 34]});
    end
    for (int k = 0; k < 3; k++) begin
      uc[k][0] = $signed({2'b00, u4_q[k][33:0]});
      uc[k][1] = $signed({2'b00, u4_q[k][67:34]});
      uc[k][2] = $signed(u4_q[k][UW-1:68]);
      nc[k][0] = $signed({1'b0, n4_q[k][33:0]});
      nc[k][1] = $signed({{2{n4_q[k][NW-1]}}, n4_q[k][NW-1:34]});
    end
    for (int k = 0; k < 3; k++) begin
      for (int cu = 0; cu < 3; cu++) begin
        for (int cn = 0; cn < 2; cn++) begin
          tp5_d[k][0][cu*2+cn] = uc[IdxA[k]][cu] * nc[IdxB[k]][cn];
          tp5_d[k][1][cu*2+cn] = uc[IdxB[k]][cu] * nc[IdxA[k]][cn];
        end
      end
      for (int j = 0; j < 4; j++) begin
        cd5_d[k][j] = c4_q[k] * dc[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tp5_q <= tp5_d;
      cd5_q <= cd5_d;
      d5_q  <= d4_q;
    end
  end

  // stage 6: sum the partials
  logic signed [NumW-1:0] t6_d [3], t6_q [3], cd6_d [3], cd6_q [3];
  logic [DenW-1:0]        d6_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t6_d[k]  = '0;
      cd6_d[k] = '0;
      for (int cu = 0; cu < 3; cu++) begin
        for (int cn = 0; cn < 2; cn++) begin
          t6_d[k] = t6_d[k]
                  + ((NumW'(tp5_q[k][0][cu*2+cn]) - NumW'(tp5_q[k][1][cu*2+cn]))
                     <<< (34 * (cu + cn)));
        end
      end
      for (int j = 0; j < 4; j++) begin
        cd6_d[k] = cd6_d[k] + (NumW'(cd5_q[k][j]) <<< (34 * j));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t6_q  <= t6_d;
      cd6_q <= cd6_d;
      d6_q  <= d5_q;
    end
  end

  // stage 7: numerator C * D + t
  logic signed [NumW-1:0] num7_q [3];
  logic [DenW-1:0]        d7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        num7_q[k] <= t6_q[k] + cd6_q[k];
      end
      d7_q <= d6_q;
    end
  end

  // stage 8: sign and magnitude
  logic [MagW-1:0] mag8_d [3], mag8_q [3];
  logic [2:0]      neg8_d, neg8_q;
  logic [DenW-1:0] d8_q;
  logic            deg8_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg8_d[k] = num7_q[k][NumW-1];
      mag8_d[k] = MagW'(neg8_d[k] ? -num7_q[k] : num7_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag8_q <= mag8_d;
      neg8_q <= neg8_d;
      d8_q   <= d7_q;
      deg8_q <= (d7_q == '0);
    end
  end

  logic div_vld;
  res_t div_res;

  tcc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_q[7]),
    .mag_i  (mag8_q),
    .den_i  (d8_q),
    .neg_i  (neg8_q),
    .deg_i  (deg8_q),
    .vld_o  (div_vld),
    .res_o  (div_res)
  );

  // output register plus one skid entry; the pipe halts only when the skid is full
  logic out_v_q, skid_v_q, out_free;
  res_t out_q, skid_q;

  assign en       = !skid_v_q;
  assign out_free = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_free) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end
    end else if (div_vld) begin
      if (out_free) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (out_free) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_free) begin
        out_q <= skid_q;
      end
    end else if (div_vld) begin
      if (out_free) begin
        out_q <= div_res;
      end else begin
        skid_q <= div_res;
      end
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = out_v_q;
  assign center_x_o  = out_q.x;
  assign center_y_o  = out_q.y;
  assign center_z_o  = out_q.z;
  assign status_o    = out_q.status;

endmodule

// File: hw/rtl/tcc_checker.sv
// ----------------------------------------------------------------------------
// tcc_checker: port-level checks for triangle_circumcenter
// Output hold under stall, degenerate result encoding, input backpressure.
// ----------------------------------------------------------------------------
module tcc_checker import tcc_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic signed [CoordW-1:0] ax_i,
  input logic signed [CoordW-1:0] ay_i,
  input logic signed [CoordW-1:0] az_i,
  input logic signed [CoordW-1:0] bx_i,
  input logic signed [CoordW-1:0] by_coord_i,
  input logic signed [CoordW-1:0] bz_i,
  input logic signed [CoordW-1:0] cx_i,
  input logic signed [CoordW-1:0] cy_i,
  input logic signed [CoordW-1:0] cz_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [CoordW-1:0] center_x_o,
  input logic signed [CoordW-1:0] center_y_o,
  input logic signed [CoordW-1:0] center_z_o,
  input logic [1:0]               status_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(center_x_o) &&
    $stable(center_y_o) && $stable(center_z_o) && $stable(status_o))
    else $error("result changed while stalled");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_DEGEN |->
    center_x_o == '0 && center_y_o == '0 && center_z_o == '0)
    else $error("degenerate result with nonzero center");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> $past(out_valid_o && !out_ready_i))
    else $error("input stalled without an output stall");

endmodule

bind triangle_circumcenter tcc_checker u_tcc_checker (.*);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the triangle circumcenter pipeline
// Drives triangle requests with random gaps and checks every result against
// an exact wide-integer model of the circumcenter. The model covers the
// planar cases, degenerate triangles and saturation of out-of-range centers.
// ----------------------------------------------------------------------------
module tb;
  import tcc_pkg::*;

  typedef logic signed [319:0] wide_t;
  typedef logic signed [CoordW-1:0] coord_t;
  typedef coord_t tri_t [9];

  // --------------------------------------------------------------------------
  class circumcenter_sb;
    res_t centers_q[$];
    int   n_fail;
    int   n_degen, n_sat, n_ok;

    function res_t circumcenter(tri_t v);
      wide_t a[3], b[3], c[3], n[3], u[3], t[3];
      wide_t den, aa, bb, num, quo;
      wide_t max_c, min_c;
      res_t  r;
      logic  sat;
      max_c = wide_t'(64'sd2147483647);
      min_c = -wide_t'(64'sd2147483648);
      for (int k = 0; k < 3; k++) begin
        c[k] = wide_t'(v[6+k]);
        a[k] = wide_t'(v[k]) - c[k];
        b[k] = wide_t'(v[3+k]) - c[k];
      end
      for (int k = 0; k < 3; k++)
        n[k] = a[(k+1)%3] * b[(k+2)%3] - a[(k+2)%3] * b[(k+1)%3];
      den = 2 * (n[0]*n[0] + n[1]*n[1] + n[2]*n[2]);
      r = '0;
      if (den == 0) begin
        r.status = ST_DEGEN;
        return r;
      end
      aa = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
      bb = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
      for (int k = 0; k < 3; k++) u[k] = aa * b[k] - bb * a[k];
      for (int k = 0; k < 3; k++)
        t[k] = u[(k+1)%3] * n[(k+2)%3] - u[(k+2)%3] * n[(k+1)%3];
      sat = 1'b0;
      for (int k = 0; k < 3; k++) begin
        num = c[k] * den + t[k];
        quo = num / den;  // truncates toward zero
        if (quo > max_c) begin
          quo = max_c; sat = 1'b1;
        end else if (quo < min_c) begin
          quo = min_c; sat = 1'b1;
        end
        case (k)
          0: r.x = quo[CoordW-1:0];
          1: r.y = quo[CoordW-1:0];
          default: r.z = quo[CoordW-1:0];
        endcase
      end
      r.status = sat ? ST_SAT : ST_OK;
      return r;
    endfunction

    function void note_request(tri_t v);
      res_t r;
      r = circumcenter(v);
      case (r.status)
        ST_DEGEN: n_degen++;
        ST_SAT:   n_sat++;
        default:  n_ok++;
      endcase
      centers_q.push_back(r);
    endfunction

    function void check_result(coord_t x, coord_t y, coord_t z, logic [1:0] st);
      res_t e;
      if (centers_q.size() == 0) begin
        $error("unexpected result x=%0d y=%0d z=%0d status=%0d", x, y, z, st);
        n_fail++;
        return;
      end
      e = centers_q.pop_front();
      if (x !== e.x) begin
        $error("center_x: expected %0d, got %0d", e.x, x); n_fail++;
      end
      if (y !== e.y) begin
        $error("center_y: expected %0d, got %0d", e.y, y); n_fail++;
      end
      if (z !== e.z) begin
        $error("center_z: expected %0d, got %0d", e.z, z); n_fail++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st); n_fail++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_ready_o;
  coord_t ax_i = '0, ay_i = '0, az_i = '0;
  coord_t bx_i = '0, by_coord_i = '0, bz_i = '0;
  coord_t cx_i = '0, cy_i = '0, cz_i = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  coord_t center_x_o, center_y_o, center_z_o;
  logic [1:0] status_o;

  triangle_circumcenter DUT (.*);

  always #5 clk_i = ~clk_i;

  circumcenter_sb sb = new();
  int  n_sent, n_recv;
  bit  no_idle;      // stretch with no gaps on either side
  bit  long_hold;    // receiver holds off once for a long stretch
  bit  stim_done;

  localparam coord_t CMax = 32'sh7fffffff;
  localparam coord_t CMin = 32'sh80000000;

  task automatic send_request(tri_t v);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    {ax_i, ay_i, az_i} = {v[0], v[1], v[2]};
    {bx_i, by_coord_i, bz_i} = {v[3], v[4], v[5]};
    {cx_i, cy_i, cz_i} = {v[6], v[7], v[8]};
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(v);
    n_sent++;
    @(negedge clk_i);
  endtask

  function automatic coord_t small_c();
    return coord_t'($urandom_range(0, 4000)) - 2000;
  endfunction

  function automatic tri_t random_tri();
    tri_t v;
    int   kind;
    coord_t s;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) v[i] = (kind < 3) ? coord_t'($urandom) : small_c();
    case (kind)
      3: begin s = (kind == 3) ? coord_t'($urandom) : 0; v[2] = s; v[5] = s; v[8] = s; end
      4: begin s = coord_t'($urandom); v[1] = s; v[4] = s; v[7] = s; end
      5: begin s = coord_t'($urandom); v[0] = s; v[3] = s; v[6] = s; end
      6: begin
        // collinear: B and C on the line through A
        for (int i = 0; i < 3; i++) begin
          v[3+i] = v[i] + (v[i] >>> 4) * 3;
          v[6+i] = v[i] - (v[i] >>> 4) * 5;
        end
      end
      7: begin
        // nearly collinear, wide spread: center far away
        for (int i = 0; i < 3; i++) v[i] = coord_t'($urandom) >>> 2;
        for (int i = 0; i < 3; i++) begin
          v[3+i] = -v[i];
          v[6+i] = coord_t'($urandom_range(0, 2)) - 1;
        end
      end
      8: begin
        // coincident pair
        v[3] = v[0]; v[4] = v[1]; v[5] = v[2];
      end
      default: ;
    endcase
    return v;
  endfunction

  // sender
  initial begin
    tri_t d[$];
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    d.push_back('{0,0,0, 65536,0,0, 0,65536,0});
    d.push_back('{CMax,CMax,CMax, CMin,CMin,CMin, CMax,CMin,CMax});
    d.push_back('{CMin,CMin,CMin, CMax,CMax,CMin, CMin,CMax,CMax});
    d.push_back('{CMax,0,CMin, CMin,CMax,0, 0,CMin,CMax});
    d.push_back('{-1,-1,-1, 1,1,1, 1,-1,1});
    d.push_back('{5,5,5, 5,5,5, 5,5,5});                       // all coincident
    d.push_back('{1,2,3, 1,2,3, 7,8,9});                       // two coincident
    d.push_back('{0,0,0, 100,200,300, 300,600,900});           // collinear
    d.push_back('{CMin,0,0, 0,0,0, CMax,0,0});                 // collinear extremes
    d.push_back('{10,20,777, -30,45,777, 60,-5,777});          // shared z
    d.push_back('{10,-9,7, -30,-9,45, 60,-9,-5});              // shared y
    d.push_back('{-4,20,7, -4,45,33, -4,-5,90});               // shared x
    d.push_back('{CMax,CMax,CMax, CMax,CMin,CMax, CMin,CMax,CMax}); // shared z at max
    d.push_back('{CMin,0,0, 0,1,0, CMax,0,0});                 // far center, saturates
    d.push_back('{CMin,CMin,5, CMax,CMax,5, 0,1,5});
    d.push_back('{0,0,0, 3,0,0, 0,0,3});                       // odd division
    d.push_back('{0,0,0, -3,0,0, 0,0,-3});
    d.push_back('{-1,0,0, 0,-1,0, 0,0,-1});
    d.push_back('{32'sh55555555,32'shaaaaaaaa,0, 32'shaaaaaaaa,0,32'sh55555555,
                  0,32'sh55555555,32'shaaaaaaaa});
    foreach (d[i]) send_request(d[i]);
    for (int i = 0; i < 1250; i++) begin
      if (i % 200 == 0) no_idle = ~no_idle;
      if (i == 350) long_hold = 1'b1;
      if (i == 700) begin
        // let the pipeline drain completely before going on
        in_valid_i = 1'b0;
        while (sb.centers_q.size() != 0) @(negedge clk_i);
      end
      send_request(random_tri());
    end
    in_valid_i = 1'b0;
    while (sb.centers_q.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    $display("sent %0d triangles, checked %0d centers", n_sent, n_recv);
    $display("ok %0d, degenerate %0d, saturated %0d", sb.n_ok, sb.n_degen, sb.n_sat);
    if (sb.n_fail == 0 && sb.centers_q.size() == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  // receiver
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold && !held) begin
        held = 1'b1;
        stall = 300;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 12);
      end
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(center_x_o, center_y_o, center_z_o, status_o);
      n_recv++;
    end
  end

  initial begin
    #3000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
